// ===== hdl/bmsi_pkg.sv =====
// Shared types and constants for the banked mapper with scanline interrupt.
package bmsi_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int NUM_BEATS  = 12;
  localparam int NUM_PRG    = 4;
  localparam int BEAT_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN     = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PRG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
  localparam logic [15:0] REG_MIRRORING    = 16'hA000;
  localparam logic [15:0] REG_PRG_RAM      = 16'hA001;
  localparam logic [15:0] REG_IRQ_COUNT    = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD   = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

  localparam logic [2:0] SEL_PAIR_LOW   = 3'd0;
  localparam logic [2:0] SEL_PAIR_HIGH  = 3'd1;
  localparam logic [2:0] SEL_SINGLE_0   = 3'd2;
  localparam logic [2:0] SEL_SINGLE_1   = 3'd3;
  localparam logic [2:0] SEL_SINGLE_2   = 3'd4;
  localparam logic [2:0] SEL_SINGLE_3   = 3'd5;
  localparam logic [2:0] SEL_PRG_FIRST  = 3'd6;
  localparam logic [2:0] SEL_PRG_SECOND = 3'd7;

  localparam logic [7:0] PAIR_EVEN_MASK = 8'hFE;
  localparam logic [9:0] VISIBLE_LINES  = 10'd240;

  localparam logic [8:0] RESET_PRG_BANK_COUNT = 9'd32;

  typedef struct packed {
    logic                  tick;
    logic                  fired;
    logic                  ram;
    logic                  mirror;
    logic [NUM_BEATS-1:0][7:0] banks;
  } job_t;

endpackage

// ===== hdl/bmsi_regs.sv =====
// Mapper register file, bus write decode, IRQ counter and snapshot job register.
module bmsi_regs
  import bmsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  operation,
  input  logic [15:0]           address,
  input  logic [7:0]            data,
  input  logic [9:0]            scanline,
  input  logic                  render_enabled,
  input  logic                  job_ready,
  output logic                  job_valid,
  output job_t                  job
);

  logic [8:0] prg_bank_count;
  logic       chr_rom_present;
  logic       four_screen;

  logic [7:0]      command, command_next;
  logic [7:0]      chr_pair_low, chr_pair_low_next;
  logic [7:0]      chr_pair_high, chr_pair_high_next;
  logic [3:0][7:0] chr_single_banks, chr_single_banks_next;
  logic [7:0]      prg_first, prg_first_next;
  logic [7:0]      prg_second, prg_second_next;
  logic [7:0]      irq_count, irq_count_next;
  logic [7:0]      irq_reload, irq_reload_next;
  logic            irq_on, irq_on_next;
  logic            mirror_state, mirror_state_next;
  logic            fired;
  logic [8:0]      count_m2, count_m1;
  logic [7:0]      pair_low_odd, pair_high_odd;
  job_t            job_next;

  always_comb begin
    command_next          = command;
    chr_pair_low_next     = chr_pair_low;
    chr_pair_high_next    = chr_pair_high;
    chr_single_banks_next = chr_single_banks;
    prg_first_next        = prg_first;
    prg_second_next       = prg_second;
    irq_count_next        = irq_count;
    irq_reload_next       = irq_reload;
    irq_on_next           = irq_on;
    mirror_state_next     = mirror_state;
    fired                 = 1'b0;
    if (operation) begin
      if (irq_on && (scanline < VISIBLE_LINES) && render_enabled) begin
        if (irq_count == 8'd0) begin
          irq_count_next = irq_reload;
          fired          = 1'b1;
        end else begin
          irq_count_next = irq_count - 8'd1;
        end
      end
    end else if (address[15]) begin
      case (address & ADDR_DECODE_MASK)
        REG_BANK_SELECT: command_next = data;
        REG_BANK_DATA: begin
          case (command[2:0])
            SEL_PAIR_LOW:   chr_pair_low_next = data & PAIR_EVEN_MASK;
            SEL_PAIR_HIGH:  chr_pair_high_next = data & PAIR_EVEN_MASK;
            SEL_SINGLE_0:   chr_single_banks_next[0] = data;
            SEL_SINGLE_1:   chr_single_banks_next[1] = data;
            SEL_SINGLE_2:   chr_single_banks_next[2] = data;
            SEL_SINGLE_3:   chr_single_banks_next[3] = data;
            SEL_PRG_FIRST:  prg_first_next = data;
            SEL_PRG_SECOND: prg_second_next = data;
            default:        prg_second_next = data;
          endcase
        end
        REG_MIRRORING: begin
          if (!four_screen) begin
            mirror_state_next = data[0];
          end
        end
        REG_PRG_RAM:     irq_on_next = irq_on;
        REG_IRQ_COUNT:   irq_count_next = data;
        REG_IRQ_RELOAD:  irq_reload_next = data;
        REG_IRQ_DISABLE: irq_on_next = 1'b0;
        REG_IRQ_ENABLE:  irq_on_next = 1'b1;
        default:         irq_on_next = irq_on;
      endcase
    end
  end

  assign count_m2      = prg_bank_count - 9'd2;
  assign count_m1      = prg_bank_count - 9'd1;
  assign pair_low_odd  = chr_pair_low_next + 8'd1;
  assign pair_high_odd = chr_pair_high_next + 8'd1;

  always_comb begin
    job_next.tick   = operation;
    job_next.fired  = fired;
    job_next.ram    = ~chr_rom_present;
    job_next.mirror = mirror_state_next;
    job_next.banks[0] = command_next[6] ? count_m2[7:0] : prg_first_next;
    job_next.banks[1] = prg_second_next;
    job_next.banks[2] = command_next[6] ? prg_first_next : count_m2[7:0];
    job_next.banks[3] = count_m1[7:0];
    if (command_next[7]) begin
      job_next.banks[7:4]  = chr_single_banks_next;
      job_next.banks[8]    = chr_pair_low_next;
      job_next.banks[9]    = pair_low_odd;
      job_next.banks[10]   = chr_pair_high_next;
      job_next.banks[11]   = pair_high_odd;
    end else begin
      job_next.banks[4]    = chr_pair_low_next;
      job_next.banks[5]    = pair_low_odd;
      job_next.banks[6]    = chr_pair_high_next;
      job_next.banks[7]    = pair_high_odd;
      job_next.banks[11:8] = chr_single_banks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count   <= RESET_PRG_BANK_COUNT;
      chr_rom_present  <= 1'b1;
      four_screen      <= 1'b0;
      command          <= 8'd0;
      chr_pair_low     <= 8'd0;
      chr_pair_high    <= 8'd2;
      chr_single_banks <= {8'd7, 8'd6, 8'd5, 8'd4};
      prg_first        <= 8'd0;
      prg_second       <= 8'd1;
      irq_count        <= 8'd0;
      irq_reload       <= 8'd0;
      irq_on           <= 1'b0;
      mirror_state     <= 1'b0;
      job_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_BANK_COUNT:  prg_bank_count <= cfg_data;
          CFG_CHR_ROM_PRESENT: chr_rom_present <= cfg_data[0];
          CFG_FOUR_SCREEN:     four_screen <= cfg_data[0];
          default:             four_screen <= four_screen;
        endcase
      end
      if (accept) begin
        command          <= command_next;
        chr_pair_low     <= chr_pair_low_next;
        chr_pair_high    <= chr_pair_high_next;
        chr_single_banks <= chr_single_banks_next;
        prg_first        <= prg_first_next;
        prg_second       <= prg_second_next;
        irq_count        <= irq_count_next;
        irq_reload       <= irq_reload_next;
        irq_on           <= irq_on_next;
        mirror_state     <= mirror_state_next;
        job_valid        <= 1'b1;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

// ===== hdl/bmsi_emit.sv =====
// Result sequencer: holds the active job and walks its beats onto the output.
module bmsi_emit
  import bmsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  job_t                  job,
  output logic                  job_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  job_t                  act;
  logic                  act_valid;
  logic [BEAT_IDX_W-1:0] idx;
  logic                  beat_done;
  logic                  is_prg;
  logic [2:0]            slot;
  logic [7:0]            bank;
  logic                  uses_ram;
  logic                  irq;

  assign is_prg    = (idx < BEAT_IDX_W'(NUM_PRG));
  assign m_tlast   = act.tick || (idx == BEAT_IDX_W'(NUM_BEATS - 1));
  assign beat_done = act_valid && m_tready && m_tlast;
  assign job_ready = !act_valid || beat_done;

  always_comb begin
    if (act.tick) begin
      m_tuser  = KIND_TICK;
      slot     = 3'd0;
      bank     = 8'd0;
      uses_ram = 1'b0;
      irq      = act.fired;
    end else begin
      m_tuser  = is_prg ? KIND_PRG : KIND_CHR;
      slot     = is_prg ? idx[2:0] : 3'(idx - BEAT_IDX_W'(NUM_PRG));
      bank     = act.banks[idx];
      uses_ram = !is_prg && act.ram;
      irq      = 1'b0;
    end
  end

  assign m_tvalid = act_valid;
  assign m_tdata  = {2'b00, irq, act.mirror, uses_ram, bank, slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      idx       <= '0;
    end else if (job_ready) begin
      act_valid <= job_valid;
      idx       <= '0;
    end else if (m_tready) begin
      idx <= idx + BEAT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      act <= job;
    end
  end

endmodule

// ===== hdl/banked_mapper_with_scanline_irq_top.sv =====
// Top level of the banked mapper with scanline interrupt counter.
// A bus write beat updates the mapper registers on acceptance and yields twelve
// output beats (four 8K program windows, then eight 1K picture windows, tlast on
// the last); a scanline tick beat yields one beat carrying the irq flag. Output
// runs at one beat per cycle from the result sequencer while m_tready is high; a
// second input beat is held in the job register while the current run drains,
// and input is taken in every cycle that register is free.
module banked_mapper_with_scanline_irq_top
  import bmsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // address[15:0], data[23:16], scanline[33:24], render_enabled[34], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot[2:0], bank[10:3], uses_ram[11], mirror_horizontal[12], irq[13], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  logic job_valid;
  logic job_ready;
  job_t job;
  logic accept;

  assign s_tready = !job_valid || job_ready;
  assign accept   = s_tvalid && s_tready;

  bmsi_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .operation      (s_tuser),
    .address        (s_tdata[15:0]),
    .data           (s_tdata[23:16]),
    .scanline       (s_tdata[33:24]),
    .render_enabled (s_tdata[34]),
    .job_ready      (job_ready),
    .job_valid      (job_valid),
    .job            (job)
  );

  bmsi_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the banked mapper: directed table, then random phases per setting.
`timescale 1ns / 1ps

module tb_top;
  import bmsi_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 64;
  localparam int DIRECTED_ROWS = 26;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 40;
  localparam int PRG_SWAP_BIT  = 6;
  localparam int CHR_SWAP_BIT  = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam logic [9:0] LINE_PRE_RENDER = 10'h3FF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [2:0]        slot;
    logic [7:0]        bank;
    logic              ram;
    logic              mirror;
    logic              irq;
    logic              last;
  } window_t;

  typedef struct packed {
    logic                      op;
    logic [15:0]               addr;
    logic [7:0]                dat;
    logic [9:0]                line;
    logic                      rend;
    logic                      typed;
    logic                      fired;
    logic [0:NUM_BEATS-1][7:0] banks;
  } stim_row_t;

  localparam logic [0:NUM_BEATS-1][7:0] RESET_MAP = {
    8'd0, 8'd1, 8'd30, 8'd31, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
  localparam logic [0:NUM_BEATS-1][7:0] WIDE_PAIR_MAP = {
    8'd0, 8'd1, 8'd30, 8'd31, 8'hFE, 8'hFF, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // address[15:0], data[23:16], scanline[33:24], render_enabled[34], zero fill
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // operation[0]
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // slot[2:0], bank[10:3], uses_ram[11], mirror_horizontal[12], irq[13], zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  // kind[1:0]
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  stim_row_t beat_note = '0;
  logic      calm = 1'b0;

  logic [8:0] prg_count;
  logic       chr_rom;
  logic       four_scr;
  logic [7:0] bank_sel;
  logic [7:0] pair_lo;
  logic [7:0] pair_hi;
  logic [7:0] singles [4];
  logic [7:0] prg_a;
  logic [7:0] prg_b;
  logic [7:0] irq_cnt;
  logic [7:0] irq_refill;
  logic       irq_armed;
  logic       mirror_h;

  window_t     expected_windows [$];
  int          cycle_count = 0;
  int          mismatch_count = 0;
  int          beats_in = 0;
  int          snapshots_seen = 0;
  int          ticks_seen = 0;
  int          fires_seen = 0;
  int          cfg_writes = 0;
  int unsigned stall_left = 0;

  banked_mapper_with_scanline_irq_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_windows.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    logic [15:0]               addr;
    logic [7:0]                dat;
    logic [9:0]                line;
    logic                      fired;
    logic [8:0]                count_less;
    logic [0:NUM_PRG-1][7:0]   prg_map;
    logic [0:7][7:0]           chr_map;
    logic [0:3][7:0]           pair_banks;
    int                        lo_half;
    int                        pos;
    window_t                   want;
    window_t                   got;
    if (rst) begin
      prg_count  = RESET_PRG_BANK_COUNT;
      chr_rom    = 1'b1;
      four_scr   = 1'b0;
      bank_sel   = 8'd0;
      pair_lo    = 8'd0;
      pair_hi    = 8'd2;
      singles[0] = 8'd4;
      singles[1] = 8'd5;
      singles[2] = 8'd6;
      singles[3] = 8'd7;
      prg_a      = 8'd0;
      prg_b      = 8'd1;
      irq_cnt    = 8'd0;
      irq_refill = 8'd0;
      irq_armed  = 1'b0;
      mirror_h   = 1'b0;
      expected_windows.delete();
    end else begin
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_index)
          CFG_PRG_BANK_COUNT:  prg_count = cfg_data;
          CFG_CHR_ROM_PRESENT: chr_rom = cfg_data[0];
          CFG_FOUR_SCREEN:     four_scr = cfg_data[0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        beats_in++;
        addr = s_tdata[15:0];
        dat  = s_tdata[23:16];
        line = s_tdata[33:24];
        if (s_tuser == OP_TICK) begin
          ticks_seen++;
          fired = 1'b0;
          if (irq_armed && line < VISIBLE_LINES && s_tdata[34]) begin
            if (irq_cnt == 8'd0) begin
              irq_cnt = irq_refill;
              fired   = 1'b1;
            end else begin
              irq_cnt = irq_cnt - 8'd1;
            end
          end
          if (beat_note.typed)
            fired = beat_note.fired;
          want = {KIND_TICK, 3'd0, 8'd0, 1'b0, mirror_h, fired, 1'b1};
          expected_windows.push_back(want);
        end else begin
          snapshots_seen++;
          if (addr >= REG_BANK_SELECT) begin
            case (addr & ADDR_DECODE_MASK)
              REG_BANK_SELECT: bank_sel = dat;
              REG_BANK_DATA: begin
                case (bank_sel[2:0])
                  SEL_PAIR_LOW:   pair_lo = dat & PAIR_EVEN_MASK;
                  SEL_PAIR_HIGH:  pair_hi = dat & PAIR_EVEN_MASK;
                  SEL_PRG_FIRST:  prg_a = dat;
                  SEL_PRG_SECOND: prg_b = dat;
                  default:        singles[2'(bank_sel[2:0] - SEL_SINGLE_0)] = dat;
                endcase
              end
              REG_MIRRORING: begin
                if (!four_scr)
                  mirror_h = dat[0];
              end
              REG_PRG_RAM: ;
              REG_IRQ_COUNT:   irq_cnt = dat;
              REG_IRQ_RELOAD:  irq_refill = dat;
              REG_IRQ_DISABLE: irq_armed = 1'b0;
              REG_IRQ_ENABLE:  irq_armed = 1'b1;
              default: ;
            endcase
          end

          count_less = prg_count - 9'd2;
          prg_map[0] = prg_a;
          prg_map[1] = prg_b;
          prg_map[2] = count_less[7:0];
          if (bank_sel[PRG_SWAP_BIT]) begin
            prg_map[0] = count_less[7:0];
            prg_map[2] = prg_a;
          end
          count_less = prg_count - 9'd1;
          prg_map[3] = count_less[7:0];

          pair_banks = {pair_lo, pair_lo + 8'd1, pair_hi, pair_hi + 8'd1};
          lo_half = bank_sel[CHR_SWAP_BIT] ? 4 : 0;
          for (int i = 0; i < 4; i++) begin
            chr_map[lo_half + i]     = pair_banks[i];
            chr_map[4 - lo_half + i] = singles[i];
          end

          for (int i = 0; i < NUM_BEATS; i++) begin
            pos = (i < NUM_PRG) ? i : i - NUM_PRG;
            want.kind   = (i < NUM_PRG) ? KIND_PRG : KIND_CHR;
            want.slot   = pos[2:0];
            want.bank   = (i < NUM_PRG) ? prg_map[pos] : chr_map[pos];
            if (beat_note.typed)
              want.bank = beat_note.banks[i];
            want.ram    = (i >= NUM_PRG) && !chr_rom;
            want.mirror = mirror_h;
            want.irq    = 1'b0;
            want.last   = (i == NUM_BEATS - 1);
            expected_windows.push_back(want);
          end
        end
      end

      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[11], m_tdata[12], m_tdata[13],
               m_tlast};
        if (expected_windows.size() == 0) begin
          report_mismatch("beat with nothing pending, kind", int'(got.kind), -1);
        end else begin
          want = expected_windows.pop_front();
          if (want.kind == KIND_TICK && want.irq)
            fires_seen++;
          if (got.kind != want.kind)
            report_mismatch("kind", int'(got.kind), int'(want.kind));
          if (got.slot != want.slot)
            report_mismatch("slot", int'(got.slot), int'(want.slot));
          if (got.bank != want.bank)
            report_mismatch("bank", int'(got.bank), int'(want.bank));
          if (got.ram != want.ram)
            report_mismatch("uses_ram", int'(got.ram), int'(want.ram));
          if (got.mirror != want.mirror)
            report_mismatch("mirror", int'(got.mirror), int'(want.mirror));
          if (got.irq != want.irq)
            report_mismatch("irq", int'(got.irq), int'(want.irq));
          if (got.last != want.last)
            report_mismatch("tlast", int'(got.last), int'(want.last));
        end
      end
    end
  end

  function automatic stim_row_t wr_row(input logic [15:0] addr, input logic [7:0] dat);
    stim_row_t row;
    row      = '0;
    row.op   = OP_WRITE;
    row.addr = addr;
    row.dat  = dat;
    row.line = 10'($urandom_range(0, 511));
    row.rend = 1'($urandom_range(0, 1));
    return row;
  endfunction

  function automatic stim_row_t tick_row(input logic [9:0] line, input logic rend);
    stim_row_t row;
    row      = '0;
    row.op   = OP_TICK;
    row.addr = 16'($urandom_range(0, 65535));
    row.dat  = 8'($urandom_range(0, 255));
    row.line = line;
    row.rend = rend;
    return row;
  endfunction

  function automatic stim_row_t wr_typed(input logic [15:0] addr, input logic [7:0] dat,
                                         input logic [0:NUM_BEATS-1][7:0] banks);
    stim_row_t row;
    row       = wr_row(addr, dat);
    row.typed = 1'b1;
    row.banks = banks;
    return row;
  endfunction

  function automatic stim_row_t tick_typed(input logic [9:0] line, input logic rend,
                                           input logic fired);
    stim_row_t row;
    row       = tick_row(line, rend);
    row.typed = 1'b1;
    row.fired = fired;
    return row;
  endfunction

  function automatic logic [15:0] reg_addr(input logic [15:0] base);
    logic [15:0] jitter;
    jitter = 16'($urandom_range(0, 65535));
    return (base & ADDR_DECODE_MASK) | (jitter & ~ADDR_DECODE_MASK);
  endfunction

  function automatic logic [9:0] rand_line();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 15)
      return 10'($urandom_range(0, 239));
    if (pick < 18)
      return 10'($urandom_range(240, 511));
    return LINE_PRE_RENDER;
  endfunction

  task automatic send_beat(input stim_row_t row);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= row.op;
    s_tdata   <= {5'd0, row.rend, row.line, row.dat, row.addr};
    beat_note <= row;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_item(output int beats);
    int        pick;
    stim_row_t row;
    pick  = $urandom_range(0, 99);
    beats = 1;
    if (pick < 30) begin
      send_beat(wr_row(reg_addr(REG_BANK_SELECT), 8'($urandom_range(0, 255))));
      send_beat(wr_row(reg_addr(REG_BANK_DATA), 8'($urandom_range(0, 255))));
      beats = 2;
    end else if (pick < 37) begin
      send_beat(wr_row(reg_addr(REG_MIRRORING), 8'($urandom_range(0, 255))));
    end else if (pick < 40) begin
      send_beat(wr_row(reg_addr(REG_PRG_RAM), 8'($urandom_range(0, 255))));
    end else if (pick < 48) begin
      send_beat(wr_row(reg_addr(REG_IRQ_COUNT),
                       8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 7))));
      send_beat(wr_row(reg_addr(REG_IRQ_RELOAD),
                       8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 7))));
      send_beat(wr_row(reg_addr(REG_IRQ_ENABLE), 8'($urandom_range(0, 255))));
      beats = 3;
    end else if (pick < 80) begin
      send_beat(tick_row(rand_line(), $urandom_range(0, 9) != 0));
    end else if (pick < 84) begin
      send_beat(wr_row(reg_addr(REG_IRQ_DISABLE), 8'($urandom_range(0, 255))));
    end else begin
      row      = tick_row($urandom_range(0, 1) ? rand_line() : 10'($urandom_range(0, 511)),
                          1'($urandom_range(0, 1)));
      row.op   = 1'($urandom_range(0, 1));
      row.addr = 16'($urandom_range(0, 65535));
      send_beat(row);
    end
  endtask

  initial begin : stimulus
    stim_row_t  directed_rows [DIRECTED_ROWS];
    logic [8:0] count_plan [4];
    logic       rom_plan [4];
    logic       quad_plan [4];
    int         sent;
    int         beats;
    bit         paused;

    directed_rows[0]  = wr_typed(16'h0000, 8'h00, RESET_MAP);
    directed_rows[1]  = wr_typed(16'h7FFF, 8'hFF, RESET_MAP);
    directed_rows[2]  = tick_typed(10'd0, 1'b1, 1'b0);
    directed_rows[3]  = wr_row(REG_BANK_SELECT, 8'h00);
    directed_rows[4]  = wr_typed(REG_BANK_DATA, 8'hFF, WIDE_PAIR_MAP);
    directed_rows[5]  = wr_row(REG_BANK_SELECT, 8'h01);
    directed_rows[6]  = wr_row(REG_BANK_DATA, 8'h01);
    directed_rows[7]  = wr_row(REG_BANK_SELECT, 8'h02);
    directed_rows[8]  = wr_row(REG_BANK_DATA, 8'hAA);
    directed_rows[9]  = wr_row(REG_BANK_SELECT, 8'h05);
    directed_rows[10] = wr_row(REG_BANK_DATA, 8'h00);
    directed_rows[11] = wr_row(REG_BANK_SELECT, 8'h46);
    directed_rows[12] = wr_row(REG_BANK_DATA, 8'h10);
    directed_rows[13] = wr_row(REG_BANK_SELECT, 8'hC7);
    directed_rows[14] = wr_row(REG_BANK_DATA, 8'hFF);
    directed_rows[15] = wr_row(REG_MIRRORING, 8'h01);
    directed_rows[16] = wr_row(REG_PRG_RAM, 8'hFF);
    directed_rows[17] = wr_row(REG_IRQ_COUNT, 8'h00);
    directed_rows[18] = wr_row(REG_IRQ_RELOAD, 8'h02);
    directed_rows[19] = wr_row(16'hFFFF, 8'h00);
    directed_rows[20] = tick_typed(10'd0, 1'b1, 1'b1);
    directed_rows[21] = tick_typed(10'd240, 1'b1, 1'b0);
    directed_rows[22] = tick_typed(LINE_PRE_RENDER, 1'b1, 1'b0);
    directed_rows[23] = tick_typed(10'd239, 1'b0, 1'b0);
    directed_rows[24] = wr_row(REG_IRQ_DISABLE, 8'h00);
    directed_rows[25] = tick_typed(10'd100, 1'b1, 1'b0);

    count_plan = '{9'd2, 9'd256, 9'd0, 9'd511};
    rom_plan   = '{1'b0, 1'b1, 1'b1, 1'b0};
    quad_plan  = '{1'b1, 1'b0, 1'b1, 1'b0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_beat(directed_rows[i]);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      if (ph < 4) begin
        cfg_write(CFG_PRG_BANK_COUNT, count_plan[ph]);
        cfg_write(CFG_CHR_ROM_PRESENT, 9'(rom_plan[ph]));
        cfg_write(CFG_FOUR_SCREEN, 9'(quad_plan[ph]));
      end else begin
        cfg_write(CFG_PRG_BANK_COUNT, 9'($urandom_range(2, 256)));
        cfg_write(CFG_CHR_ROM_PRESENT, 9'($urandom_range(0, 1)));
        cfg_write(CFG_FOUR_SCREEN, 9'($urandom_range(0, 1)));
      end
      calm   = (ph == PHASE_COUNT - 1);
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        send_random_item(beats);
        sent += beats;
        if (ph == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();

    $display("run covered %0d input beats: %0d bus writes with window snapshots, %0d ticks",
             beats_in, snapshots_seen, ticks_seen);
    $display("%0d interrupts fired, %0d register writes, %0d mismatches",
             fires_seen, cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmsi_pkg.sv
hdl/bmsi_regs.sv
hdl/bmsi_emit.sv
hdl/banked_mapper_with_scanline_irq_top.sv
tb/sv/tb_top.sv
